// ===== rtl/core/fx1714_pkg.sv =====
// Shared types and constants for the 17.14 fixed-point ALU.
// No dependencies; used by every module of the core.
`default_nettype none

package fx1714_pkg;

    // Default fraction width
    localparam int FRAC_BITS_DEF = 14;

    // Action codes
    localparam logic [3:0] ACT_ITOFP  = 4'd0;
    localparam logic [3:0] ACT_TRUNC  = 4'd1;
    localparam logic [3:0] ACT_ROUND  = 4'd2;
    localparam logic [3:0] ACT_ADD    = 4'd3;
    localparam logic [3:0] ACT_ADDINT = 4'd4;
    localparam logic [3:0] ACT_SUB    = 4'd5;
    localparam logic [3:0] ACT_SUBINT = 4'd6;
    localparam logic [3:0] ACT_MUL    = 4'd7;
    localparam logic [3:0] ACT_MULINT = 4'd8;
    localparam logic [3:0] ACT_DIV    = 4'd9;
    localparam logic [3:0] ACT_DIVINT = 4'd10;

    // Control and side data that travels down the pipeline with each word
    typedef struct packed {
        logic        is_div;
        logic        is_mul;
        logic        is_mulint;
        logic        dz;
        logic        neg;
        logic [31:0] early;
        logic [31:0] divisor;
    } pipe_t;

endpackage

`default_nettype wire

// ===== rtl/core/fixed_point_17_14_alu_core.sv =====
// Top level of the signed 17.14 fixed-point ALU.
// Depends on fx1714_pkg, fx1714_front and fx1714_div_stage.
//
// Usage:
//   Input stream s_*: s_tuser carries the action code, s_tdata the two operands.
//   Output stream m_*: m_tdata carries the 32-bit result, m_tuser the
//   divide-by-zero flag. One result word per input word, in order.
//   Each word passes three front stages (decode, multiply, product scaling),
//   one restoring-division step per quotient bit (32 + FRAC_BITS), and the
//   output register. Every action takes the same path, so words never
//   overtake one another.
//   Throughput is one word per cycle while the receiver takes results; the
//   divider is fully unrolled into stages, one quotient bit each.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver drops m_tready with a result waiting, the whole pipeline
//   holds and s_tready falls in the same cycle; nothing is lost or repeated.
`default_nettype none

module fixed_point_17_14_alu_core #(
    parameter int FRAC_BITS = fx1714_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  wire logic [3:0]  s_tuser,   // [3:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] result_value
    output logic             m_tuser    // [0] divide_by_zero
);

    localparam int QW = 32 + FRAC_BITS;

    logic en;

    logic                valid_s [0:QW];
    fx1714_pkg::pipe_t   ctl_s   [0:QW];
    logic [31:0]         rem_s   [0:QW];
    logic [QW-1:0]       q_s     [0:QW];

    logic                out_valid_reg;
    logic [31:0]         out_data_reg, out_data_next;
    logic                out_dz_reg;
    logic [QW-1:0]       q_signed;

    // Global advance: move when the output is empty or being taken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    fx1714_front #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .action    (s_tuser),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .out_valid (valid_s[0]),
        .out_ctl   (ctl_s[0]),
        .out_dvd   (q_s[0])
    );
    assign rem_s[0] = 32'd0;

    // Division chain, one quotient bit per stage
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        fx1714_div_stage #(
            .QW (QW)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_s[i]),
            .in_ctl    (ctl_s[i]),
            .in_rem    (rem_s[i]),
            .in_q      (q_s[i]),
            .out_valid (valid_s[i+1]),
            .out_ctl   (ctl_s[i+1]),
            .out_rem   (rem_s[i+1]),
            .out_q     (q_s[i+1])
        );
    end

    // Result select: signed quotient or the early result
    always_comb
    begin
        q_signed      = ctl_s[QW].neg ? ({QW{1'b0}} - q_s[QW]) : q_s[QW];
        out_data_next = ctl_s[QW].is_div ? q_signed[31:0] : ctl_s[QW].early;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_s[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_dz_reg   <= ctl_s[QW].dz;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_dz_reg;

    // Zero divisor always yields a zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("divide-by-zero word with nonzero result");

    // Input side stalls exactly when a result is held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not track output stall");

    // A held result stays put and the pipeline behind it freezes
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(valid_s[QW]) && $stable(q_s[QW]))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== rtl/core/fx1714_front.sv =====
// Front end of the ALU: decode, add/sub/convert, 32x32 multiply and divide setup.
// Three register stages; depends on fx1714_pkg.
`default_nettype none

module fx1714_front #(
    parameter int FRAC_BITS = fx1714_pkg::FRAC_BITS_DEF,
    parameter int QW        = 32 + FRAC_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [3:0]          action,
    input  wire logic signed [31:0]  operand_a,
    input  wire logic signed [31:0]  operand_b,
    output logic                     out_valid,
    output fx1714_pkg::pipe_t        out_ctl,
    output logic [QW-1:0]            out_dvd
);

    localparam logic signed [33:0] ONE_M1 = (34'sd1 <<< FRAC_BITS) - 34'sd1;
    localparam logic signed [33:0] HALF   = 34'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] ONE_M1_W = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    // Stage A registers
    logic                    valid_a_reg;
    fx1714_pkg::pipe_t       ctl_a_reg, ctl_a_next;
    logic signed [31:0]      a_a_reg, b_a_reg;
    logic [QW-1:0]           dvd_a_reg, dvd_a_next;

    // Stage B registers
    logic                    valid_b_reg;
    fx1714_pkg::pipe_t       ctl_b_reg;
    logic signed [63:0]      prod_b_reg;
    logic [QW-1:0]           dvd_b_reg;

    // Stage C registers
    logic                    valid_c_reg;
    fx1714_pkg::pipe_t       ctl_c_reg, ctl_c_next;
    logic [QW-1:0]           dvd_c_reg;

    logic signed [33:0] a_w, b_w, rnd_w, trunc_w, round_w;
    logic [31:0]        a_abs, b_abs;
    logic signed [63:0] mul_adj;

    // Stage A: decode and simple results
    always_comb
    begin
        a_w     = {{2{operand_a[31]}}, operand_a};
        b_w     = {{2{operand_b[31]}}, operand_b};
        a_abs   = operand_a[31] ? (32'd0 - operand_a) : operand_a;
        b_abs   = operand_b[31] ? (32'd0 - operand_b) : operand_b;
        trunc_w = (a_w + (operand_a[31] ? ONE_M1 : 34'sd0)) >>> FRAC_BITS;
        rnd_w   = operand_a[31] ? (a_w - HALF) : (a_w + HALF);
        round_w = (rnd_w + (rnd_w[33] ? ONE_M1 : 34'sd0)) >>> FRAC_BITS;

        ctl_a_next         = '0;
        ctl_a_next.neg     = operand_a[31] ^ operand_b[31];
        ctl_a_next.divisor = b_abs;
        dvd_a_next         = '0;
        case (action)
            fx1714_pkg::ACT_ITOFP:  ctl_a_next.early = 32'(a_w <<< FRAC_BITS);
            fx1714_pkg::ACT_TRUNC:  ctl_a_next.early = trunc_w[31:0];
            fx1714_pkg::ACT_ROUND:  ctl_a_next.early = round_w[31:0];
            fx1714_pkg::ACT_ADD:    ctl_a_next.early = 32'(a_w + b_w);
            fx1714_pkg::ACT_ADDINT: ctl_a_next.early = 32'(a_w + (b_w <<< FRAC_BITS));
            fx1714_pkg::ACT_SUB:    ctl_a_next.early = 32'(a_w - b_w);
            fx1714_pkg::ACT_SUBINT: ctl_a_next.early = 32'(a_w - (b_w <<< FRAC_BITS));
            fx1714_pkg::ACT_MUL:    ctl_a_next.is_mul = 1'b1;
            fx1714_pkg::ACT_MULINT: ctl_a_next.is_mulint = 1'b1;
            fx1714_pkg::ACT_DIV:
            begin
                ctl_a_next.dz     = (operand_b == 32'sd0);
                ctl_a_next.is_div = (operand_b != 32'sd0);
                dvd_a_next        = {a_abs, {FRAC_BITS{1'b0}}};
            end
            fx1714_pkg::ACT_DIVINT:
            begin
                ctl_a_next.dz     = (operand_b == 32'sd0);
                ctl_a_next.is_div = (operand_b != 32'sd0);
                dvd_a_next        = {{FRAC_BITS{1'b0}}, a_abs};
            end
            default:                ctl_a_next.early = 32'd0;
        endcase
    end

    // Stage C: scale the product back
    always_comb
    begin
        mul_adj    = (prod_b_reg + (prod_b_reg[63] ? ONE_M1_W : 64'sd0)) >>> FRAC_BITS;
        ctl_c_next = ctl_b_reg;
        if (ctl_b_reg.is_mul)
            ctl_c_next.early = mul_adj[31:0];
        else if (ctl_b_reg.is_mulint)
            ctl_c_next.early = prod_b_reg[31:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_a_reg  <= ctl_a_next;
            a_a_reg    <= operand_a;
            b_a_reg    <= operand_b;
            dvd_a_reg  <= dvd_a_next;
            ctl_b_reg  <= ctl_a_reg;
            prod_b_reg <= a_a_reg * b_a_reg;
            dvd_b_reg  <= dvd_a_reg;
            ctl_c_reg  <= ctl_c_next;
            dvd_c_reg  <= dvd_b_reg;
        end
    end

    assign out_valid = valid_c_reg;
    assign out_ctl   = ctl_c_reg;
    assign out_dvd   = dvd_c_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fx1714_div_stage.sv =====
// One restoring-division step with its pipeline register.
// Depends on fx1714_pkg.
`default_nettype none

module fx1714_div_stage #(
    parameter int QW = 46
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire fx1714_pkg::pipe_t  in_ctl,
    input  wire logic [31:0]        in_rem,
    input  wire logic [QW-1:0]      in_q,
    output logic                    out_valid,
    output fx1714_pkg::pipe_t       out_ctl,
    output logic [31:0]             out_rem,
    output logic [QW-1:0]           out_q
);

    logic                valid_reg;
    fx1714_pkg::pipe_t   ctl_reg;
    logic [31:0]         rem_reg, rem_next;
    logic [QW-1:0]       q_reg, q_next;
    logic [32:0]         rem_sh;
    logic [33:0]         diff;
    logic                ge;

    // Shift in next dividend bit, trial subtract
    always_comb
    begin
        rem_sh   = {in_rem, in_q[QW-1]};
        diff     = {1'b0, rem_sh} - {2'b00, in_ctl.divisor};
        ge       = !diff[33];
        rem_next = ge ? diff[31:0] : rem_sh[31:0];
        q_next   = {in_q[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg <= in_ctl;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;
    assign out_q     = q_reg;

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && ctl_reg.is_div |-> rem_reg < ctl_reg.divisor)
        else $error("division remainder not below divisor");

endmodule

`default_nettype wire

// ===== verif/fixed_point_17_14_alu_checker.sv =====
// Checker for the 17.14 fixed-point ALU: watches both streams, predicts each
// result from the accepted input word and compares. Depends on fx1714_pkg.
`timescale 1ns / 100ps

module fixed_point_17_14_alu_checker #(
    parameter int FRAC_BITS = fx1714_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic [3:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tuser,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [31:0] value;
        logic        dz;
    } alu_result_t;

    alu_result_t result_q[$];

    // Compute the 32-bit result of one operation with exact 64-bit intermediates
    function automatic alu_result_t alu_predict(logic [3:0] act, logic [31:0] a_raw,
                                                logic [31:0] b_raw);
        longint      a;
        longint      b;
        longint      one;
        longint      r;
        alu_result_t res;
        a   = longint'(signed'(a_raw));
        b   = longint'(signed'(b_raw));
        one = longint'(1) << FRAC_BITS;
        r   = 0;
        res.dz = 1'b0;
        case (act)
            fx1714_pkg::ACT_ITOFP:  r = a * one;
            fx1714_pkg::ACT_TRUNC:  r = a / one;
            fx1714_pkg::ACT_ROUND:  r = (a >= 0) ? (a + one / 2) / one : (a - one / 2) / one;
            fx1714_pkg::ACT_ADD:    r = a + b;
            fx1714_pkg::ACT_ADDINT: r = a + b * one;
            fx1714_pkg::ACT_SUB:    r = a - b;
            fx1714_pkg::ACT_SUBINT: r = a - b * one;
            fx1714_pkg::ACT_MUL:    r = (a * b) / one;
            fx1714_pkg::ACT_MULINT: r = a * b;
            fx1714_pkg::ACT_DIV, fx1714_pkg::ACT_DIVINT:
            begin
                if (b == 0)
                    res.dz = 1'b1;
                else if (act == fx1714_pkg::ACT_DIV)
                    r = (a * one) / b;
                else
                    r = a / b;
            end
            default:    r = 0;
        endcase
        res.value = r[31:0];
        return res;
    endfunction

    assign pending = result_q.size();

    // Predict on input words, compare on output words
    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t exp_res;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                result_q.push_back(alu_predict(s_tuser, s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result word %h dz %b", m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = result_q.pop_front();
                    if (exp_res.value !== m_tdata || exp_res.dz !== m_tuser)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: result exp %h got %h, dz exp %b got %b",
                                     exp_res.value, m_tdata, exp_res.dz, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/fixed_point_17_14_alu_core_tb.sv =====
// Testbench top for the 17.14 fixed-point ALU: drives operations with random
// gaps and back-pressure. Depends on fx1714_pkg, the ALU core and the checker module.
`timescale 1ns / 100ps

module fixed_point_17_14_alu_core_tb;

    localparam int LATENCY = fx1714_pkg::FRAC_BITS_DEF + 36;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending;
    bit          steady;

    fixed_point_17_14_alu_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    fixed_point_17_14_alu_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver stalls at random, about 8 percent of the time, never during the steady stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(99) >= 8);
    end

    // Operand with bias toward the edges of the 32-bit range
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'($urandom_range(65535)) - 32'd32768;
            3:       return {{17{1'b0}}, 15'($urandom)};
            4:       return 32'($urandom_range(3)) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word; hold it until accepted
    task automatic send_word(logic [3:0] act, logic [31:0] a, logic [31:0] b);
        if (!steady)
        begin
            while ($urandom_range(99) < 8)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] edges[6];
        logic [3:0]  act;
        int          n;
        edges = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_2000};
        steady   = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every action at edge values, zero divisors, unused codes
        send_word(fx1714_pkg::ACT_ITOFP,  32'h7fff_ffff, 32'h0);
        send_word(fx1714_pkg::ACT_TRUNC,  32'hffff_e000, 32'h0);
        send_word(fx1714_pkg::ACT_ROUND,  32'h7fff_ffff, 32'hffff_ffff);
        send_word(fx1714_pkg::ACT_ROUND,  32'h8000_0000, 32'h0);
        send_word(fx1714_pkg::ACT_ROUND,  32'hffff_e000, 32'h0);
        send_word(fx1714_pkg::ACT_ROUND,  32'h0000_2000, 32'h0);
        send_word(fx1714_pkg::ACT_ADD,    32'h7fff_ffff, 32'h1);
        send_word(fx1714_pkg::ACT_ADDINT, 32'h8000_0000, 32'hffff_ffff);
        send_word(fx1714_pkg::ACT_SUB,    32'h8000_0000, 32'h1);
        send_word(fx1714_pkg::ACT_SUBINT, 32'h7fff_ffff, 32'h8000_0000);
        send_word(fx1714_pkg::ACT_MUL,    32'h8000_0000, 32'h8000_0000);
        send_word(fx1714_pkg::ACT_MUL,    32'hffff_ffff, 32'h0000_0001);
        send_word(fx1714_pkg::ACT_MULINT, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(fx1714_pkg::ACT_DIV,    32'h1234_5678, 32'h0);
        send_word(fx1714_pkg::ACT_DIV,    32'h8000_0000, 32'hffff_ffff);
        send_word(fx1714_pkg::ACT_DIVINT, 32'h8000_0000, 32'hffff_ffff);
        send_word(fx1714_pkg::ACT_DIVINT, 32'h7fff_ffff, 32'h0);
        send_word(fx1714_pkg::ACT_DIVINT, 32'hffff_fff9, 32'h0000_0002);
        for (int c = 11; c < 16; c++)
            send_word(4'(c), 32'hffff_ffff, 32'hffff_ffff);

        // Pause the sender until the pipeline is empty
        drain();

        // Random: every action, bias toward edges, with a steady stretch
        for (n = 0; n < 1050; n++)
        begin
            steady = (n >= 400 && n < 550);
            act = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
            if ($urandom_range(9) == 0)
                send_word(act, edges[$urandom_range(5)], edges[$urandom_range(5)]);
            else if ((act == fx1714_pkg::ACT_DIV || act == fx1714_pkg::ACT_DIVINT)
                     && $urandom_range(9) == 0)
                send_word(act, pick_operand(), 32'h0);
            else
                send_word(act, pick_operand(), pick_operand());
        end
        steady = 1'b0;
        drain();
        repeat (LATENCY + 10) @(posedge clk);

        if (fail_count == 0)
            $display("** fixed_point_17_14_alu_core: PASSED **");
        else
            $display("** fixed_point_17_14_alu_core: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("** fixed_point_17_14_alu_core: FAILED **");
        $finish;
    end

endmodule

// ===== fixed_point_17_14_alu_core.f =====
rtl/core/fx1714_pkg.sv
rtl/core/fx1714_front.sv
rtl/core/fx1714_div_stage.sv
rtl/core/fixed_point_17_14_alu_core.sv
verif/fixed_point_17_14_alu_checker.sv
verif/fixed_point_17_14_alu_core_tb.sv
